// ===== design/lfce_pkg.sv =====
// Shared types and constants for the clamped-edge line FIR filter.
`default_nettype none

package lfce_pkg;

	localparam int NUM_TAPS   = 7;
	localparam int SAMPLE_W   = 16;
	localparam int TAP_W      = 18;
	localparam int PROD_W     = SAMPLE_W + TAP_W;
	localparam int ACC_W      = PROD_W + 3;
	localparam int FIFO_DEPTH = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_0         = 3'd1;

	localparam int                       UNITY_TAP_IDX   = 3;
	localparam logic signed [TAP_W-1:0]  UNITY_TAP_VALUE = 18'sd16384;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [TAP_W-1:0]    tap_t;

	typedef struct packed {
		logic                          vld;
		logic                          lst;
		logic signed [ACC_W-1:0]       acc;
		logic [NUM_TAPS-1:0][SAMPLE_W-1:0] xs;
	} lane_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       last;
	} result_t;

endpackage

`default_nettype wire

// ===== design/line_fir_clamped_edges.sv =====
// Top level of the clamped-edge line FIR filter.
//
// Input channel (in_valid/in_stall, sample, line_end) takes one sample of a
// line per cycle while in_stall is low; line_end marks the last sample.
// Output channel (out_valid/out_stall, filtered, last) gives one filtered
// sample per line position, last set on the final one of each line.
// Throughput: one item per cycle while in_stall is low. The line-end flush
// of up to R further results runs from a snapshot of the window while the
// next line's first R samples enter, so the flush itself stalls no input
// unless the next line ends within that flush.
// From an accepted item to its result on out_valid, the item passes one job
// stage, one cell per tap, one rounding stage and the result buffer write.
// A stalled output holds its item; results queue in a 16-entry buffer and
// in_stall rises when the space reserved by items already taken leaves no
// room for the offered item's results, or it owes one while a flush is pending.
// Reset sets R to 1, tap 3 to unity, others 0; it starts a fresh line and
// empties pipeline and buffer. Configuration is written with cfg_we while idle.
`default_nettype none

module line_fir_clamped_edges
	import lfce_pkg::*;
#(
	parameter int MAX_RADIUS     = 3,
	parameter int COEF_FRAC_BITS = 14
)
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire sample_t               sample,
	input  wire logic                  line_end,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output sample_t                    filtered,
	output logic                       last
);

	localparam int RMAX = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
	localparam int NT   = 2 * RMAX + 1;
	localparam int SW   = $clog2(NT + 1);
	localparam int IW   = $clog2(NT);
	localparam int RW   = $clog2(FIFO_DEPTH + 1);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS =
		{{(ACC_W - COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};

	// configuration
	logic [1:0]      kr_q;
	tap_t            taps_q [NT];
	logic [1:0]      r;

	// line state
	sample_t         win_q [NT];
	sample_t         first_q;
	logic [SW-1:0]   seen_q;

	sample_t         win_nx [NT];
	sample_t         first_nx;
	logic [SW-1:0]   seen_nx;
	logic [SW-1:0]   seen_m1;
	logic [1:0]      m_start;
	logic            has_job;
	logic [2:0]      n_res;
	logic            accept;
	logic            conflict;
	logic            room;

	// job stage
	logic            job_vld_q;
	logic            job_end_q;
	logic [1:0]      job_m_q;
	logic [1:0]      pend_q;
	sample_t         job_win_q [NT];
	sample_t         job_first_q;
	logic [SW-1:0]   job_seen_q;

	logic [2:0]      mr;
	logic [2:0]      d;
	lane_t           lane0;
	lane_t           lane [NT+1];

	// rounding stage and buffer
	logic signed [ACC_W-1:0] acc_f;
	logic signed [ACC_W-1:0] biased;
	logic signed [ACC_W-1:0] quot;
	result_t         res_nx;
	logic            sat_vld_s1;
	result_t         sat_res_s1;
	result_t         fifo_rdata;
	logic            pop;
	logic [RW-1:0]   res_q;

	assign r = (kr_q > 2'(RMAX)) ? 2'(RMAX) : kr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q <= 2'd1;
			for (int j = 0; j < NT; j++) begin
				if (j == UNITY_TAP_IDX) begin
					taps_q[j] <= UNITY_TAP_VALUE;
				end else begin
					taps_q[j] <= '0;
				end
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_KERNEL_RADIUS) begin
				kr_q <= cfg_data[1:0];
			end
			for (int j = 0; j < NT; j++) begin
				if (cfg_index == REG_TAP_0 + CFG_IDX_W'(j)) begin
					taps_q[j] <= $signed(cfg_data[TAP_W-1:0]);
				end
			end
		end
	end

	always_comb begin
		win_nx[0] = sample;
		for (int i = 1; i < NT; i++) begin
			win_nx[i] = win_q[i-1];
		end
		first_nx = (seen_q == '0) ? sample : first_q;
		seen_nx  = (seen_q == SW'(NT)) ? seen_q : seen_q + 1'b1;
		seen_m1  = seen_nx - 1'b1;
		m_start  = (seen_m1 < SW'(r)) ? 2'(seen_m1) : r;
		has_job  = line_end || (seen_nx > SW'(r));
		if (line_end) begin
			n_res = 3'(m_start) + 3'd1;
		end else begin
			n_res = has_job ? 3'd1 : 3'd0;
		end
	end

	assign conflict = (pend_q != '0) && has_job;
	assign room     = ((res_q + RW'(n_res)) <= RW'(FIFO_DEPTH));
	assign in_stall = !room || conflict;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= line_end ? '0 : seen_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q   <= win_nx;
			first_q <= first_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			job_end_q <= 1'b0;
			job_m_q   <= '0;
			pend_q    <= '0;
		end else if (accept && has_job) begin
			job_vld_q <= 1'b1;
			job_end_q <= line_end;
			job_m_q   <= line_end ? m_start : r;
			pend_q    <= line_end ? m_start : '0;
		end else if (pend_q != '0) begin
			job_vld_q <= 1'b1;
			job_m_q   <= job_m_q - 1'b1;
			pend_q    <= pend_q - 1'b1;
		end else begin
			job_vld_q <= 1'b0;
		end
	end

	// snapshot the window for this job and any flush behind it
	always_ff @(posedge clk) begin
		if (accept && has_job) begin
			job_win_q   <= win_nx;
			job_first_q <= first_nx;
			job_seen_q  <= seen_nx;
		end
	end

	always_comb begin
		lane0     = '0;
		lane0.vld = job_vld_q;
		lane0.lst = job_end_q && (job_m_q == '0);
		mr        = 3'(job_m_q) + 3'(r);
		d         = '0;
		for (int j = 0; j < NT; j++) begin
			if (3'(j) <= {r, 1'b0}) begin
				// replicate the newest sample past the line end
				d = (mr < 3'(j)) ? 3'd0 : mr - 3'(j);
				// replicate the first sample before the line start
				if (d >= 3'(job_seen_q)) begin
					lane0.xs[j] = job_first_q;
				end else begin
					lane0.xs[j] = job_win_q[d[IW-1:0]];
				end
			end
		end
	end

	assign lane[0] = lane0;

	for (genvar c = 0; c < NT; c++) begin : g_cell
		lfce_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tap      (taps_q[c]),
			.lane_in  (lane[c]),
			.lane_out (lane[c+1])
		);
	end

	always_comb begin
		acc_f  = lane[NT].acc;
		biased = acc_f + (acc_f[ACC_W-1] ? ROUND_BIAS : '0);
		quot   = biased >>> COEF_FRAC_BITS;
		if (quot > SAT_HI) begin
			res_nx.filtered = SAT_HI[SAMPLE_W-1:0];
		end else if (quot < SAT_LO) begin
			res_nx.filtered = SAT_LO[SAMPLE_W-1:0];
		end else begin
			res_nx.filtered = quot[SAMPLE_W-1:0];
		end
		res_nx.last = lane[NT].lst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_vld_s1 <= 1'b0;
		end else begin
			sat_vld_s1 <= lane[NT].vld;
		end
	end

	always_ff @(posedge clk) begin
		sat_res_s1 <= res_nx;
	end

	lfce_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (sat_vld_s1),
		.wdata    (sat_res_s1),
		.pop      (pop),
		.rdata    (fifo_rdata),
		.nonempty (out_valid)
	);

	assign pop      = out_valid && !out_stall;
	assign filtered = fifo_rdata.filtered;
	assign last     = fifo_rdata.last;

	// reserve buffer space for every result an accepted item owes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_q + (accept ? RW'(n_res) : '0) - RW'(pop);
		end
	end

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= RW'(FIFO_DEPTH))
		else $error("result reservation exceeds buffer depth");

	a_out_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_q != '0))
		else $error("output item without reservation");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(job_vld_q && job_end_q && (job_m_q == '0)) |-> (pend_q == '0))
		else $error("flush still pending after final result of line");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && line_end) |=>
		((seen_q == '0) && job_vld_q && job_end_q))
		else $error("line end did not start a flush");

endmodule

`default_nettype wire

// ===== design/lfce_cell.sv =====
// One multiply-accumulate cell of the tap chain.
`default_nettype none

module lfce_cell
	import lfce_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire tap_t  tap,
	input  wire lane_t lane_in,
	output lane_t      lane_out
);

	logic signed [PROD_W-1:0] prod;
	lane_t                    lane_nx;
	lane_t                    lane_s1;

	always_comb begin
		prod = tap * $signed(lane_in.xs[0]);
		lane_nx.vld = lane_in.vld;
		lane_nx.lst = lane_in.lst;
		lane_nx.acc = $signed(lane_in.acc) + ACC_W'(prod);
		// advance the operands by one place
		for (int i = 0; i < NUM_TAPS - 1; i++) begin
			lane_nx.xs[i] = lane_in.xs[i+1];
		end
		lane_nx.xs[NUM_TAPS-1] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
		end else begin
			lane_s1 <= lane_nx;
		end
	end

	assign lane_out = lane_s1;

endmodule

`default_nettype wire

// ===== design/lfce_fifo.sv =====
// Result buffer between the tap chain and the output channel.
`default_nettype none

module lfce_fifo
	import lfce_pkg::*;
#(
	parameter int DEPTH = 16
)
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t wdata,
	input  wire logic    pop,
	output result_t      rdata,
	output logic         nonempty
);

	localparam int AW = $clog2(DEPTH);

	result_t          mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	assign rdata    = mem_q[rp_q];
	assign nonempty = (cnt_q != '0);

endmodule

`default_nettype wire

// ===== test/line_fir_clamped_edges_tb.sv =====
// Self-checking bench for the clamped-edge line FIR filter: lines of samples against an in-bench filter.
`default_nettype none

class line_fir_tracker;
	localparam int FRAC_BITS = 14;
	localparam int MAX_R     = 3;

	logic [1:0]                   radius;
	lfce_pkg::tap_t               taps[lfce_pkg::NUM_TAPS];
	lfce_pkg::sample_t            window[lfce_pkg::NUM_TAPS];
	lfce_pkg::sample_t            first_sample;
	int                           seen;
	lfce_pkg::result_t            owed[$];
	int                           mismatches;

	function new();
		int j;
		radius = 2'd1;
		for (j = 0; j < lfce_pkg::NUM_TAPS; j++) begin
			taps[j]   = '0;
			window[j] = '0;
		end
		taps[lfce_pkg::UNITY_TAP_IDX] = lfce_pkg::UNITY_TAP_VALUE;
		first_sample = '0;
		seen = 0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [lfce_pkg::CFG_IDX_W-1:0] idx,
			logic [lfce_pkg::CFG_DATA_W-1:0] data);
		if (idx == lfce_pkg::REG_KERNEL_RADIUS) begin
			radius = data[1:0];
		end else begin
			taps[int'(idx) - int'(lfce_pkg::REG_TAP_0)] = lfce_pkg::tap_t'(data);
		end
	endfunction

	// queue one expected result at the tail
	function void owe(lfce_pkg::result_t res);
		owed = {owed, res};
	endfunction

	// m counts positions behind the newest sample
	function lfce_pkg::sample_t filter_at(int r, int m);
		longint acc;
		longint q;
		int d;
		int j;
		lfce_pkg::sample_t x;
		acc = 0;
		for (j = 0; j <= 2 * r; j++) begin
			d = m + r - j;
			if (d < 0)
				d = 0;
			x = (d >= seen) ? first_sample : window[d];
			acc += longint'(taps[j]) * longint'(x);
		end
		q = acc / (longint'(1) << FRAC_BITS);
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return lfce_pkg::sample_t'(q);
	endfunction

	function void take_sample(lfce_pkg::sample_t s, logic fin);
		int r;
		int m;
		int i;
		lfce_pkg::result_t res;
		r = (radius > MAX_R) ? MAX_R : int'(radius);
		for (i = lfce_pkg::NUM_TAPS - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = s;
		if (seen == 0)
			first_sample = s;
		if (seen < lfce_pkg::NUM_TAPS)
			seen++;
		if (!fin) begin
			if (seen > r) begin
				res.filtered = filter_at(r, r);
				res.last = 1'b0;
				owe(res);
			end
		end else begin
			m = (seen - 1 < r) ? seen - 1 : r;
			while (m >= 0) begin
				res.filtered = filter_at(r, m);
				res.last = (m == 0);
				owe(res);
				m--;
			end
			seen = 0;
		end
	endfunction

	function void match_output(lfce_pkg::sample_t f, logic l);
		lfce_pkg::result_t want;
		if (owed.size() == 0) begin
			mismatches++;
			$display("%0t: output with none owed: filtered %0d last %0b", $time, f, l);
			return;
		end
		want = owed.pop_front();
		if (f !== want.filtered) begin
			mismatches++;
			$display("%0t: filtered expected %0d actual %0d", $time, want.filtered, f);
		end
		if (l !== want.last) begin
			mismatches++;
			$display("%0t: last expected %0b actual %0b", $time, want.last, l);
		end
	endfunction
endclass

module line_fir_clamped_edges_tb;
	import lfce_pkg::*;

	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 150;
	localparam int RANDOM_ITEMS = 90;
	localparam int MIN_PHASES   = 3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	sample_t               sample;
	logic                  line_end;
	logic                  out_valid;
	logic                  out_stall;
	sample_t               filtered;
	logic                  last;

	int              send_idle;
	int              recv_idle;
	bit              hold_req;
	tap_t            kernel[NUM_TAPS];
	line_fir_tracker tracker;

	line_fir_clamped_edges uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#200000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_sample(sample, line_end);
			if (out_valid && !out_stall)
				tracker.match_output(filtered, last);
		end
	end

	initial begin
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall = ($urandom_range(99) < recv_idle);
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0, 1, 2, 3: return sample_t'($urandom);
			4, 5: return sample_t'(int'($urandom_range(512)) - 256);
			6: return 16'sh7fff;
			default: return 16'sh8000;
		endcase
	endfunction

	function automatic tap_t pick_tap();
		case ($urandom_range(7))
			0, 1: return tap_t'($urandom);
			2, 3, 4: return tap_t'(int'($urandom_range(32768)) - 16384);
			5: return {1'b0, {(TAP_W-1){1'b1}}};
			6: return {1'b1, {(TAP_W-1){1'b0}}};
			default: return '0;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// radius upper bits are noise; only the low two bits count
	task automatic write_kernel(input int r);
		logic [CFG_DATA_W-1:0] data;
		logic [CFG_IDX_W-1:0]  idx;
		int j;
		data = CFG_DATA_W'($urandom);
		data[1:0] = r[1:0];
		write_reg(REG_KERNEL_RADIUS, data);
		for (j = 0; j < NUM_TAPS; j++) begin
			idx = REG_TAP_0 + CFG_IDX_W'(j);
			write_reg(idx, kernel[j]);
		end
	endtask

	task automatic send_item(input sample_t s, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		line_end = fin;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_line(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_item(pick_sample(), i == len - 1);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		line_end = 1'b0;
		while (tracker.owed.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int fed;
		int chunk;
		int len;
		int phase;
		int j;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		line_end = 1'b0;
		send_idle = 35;
		recv_idle = 35;
		hold_req = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(sample_t'(32767), 1'b0);
		send_item(sample_t'(-32768), 1'b0);
		send_item(16'sh5555, 1'b0);
		send_item(sample_t'(-1), 1'b1);
		drain();

		// widest kernel, positive saturation, lines from one sample to past the radius
		kernel = '{default: tap_t'(131071)};
		write_kernel(3);
		send_item(sample_t'(32767), 1'b1);
		send_item(sample_t'(-32768), 1'b0);
		send_item(sample_t'(32767), 1'b1);
		send_item(sample_t'(100), 1'b0);
		send_item(sample_t'(-200), 1'b0);
		send_item(sample_t'(300), 1'b1);
		send_item(sample_t'(1), 1'b0);
		send_item(sample_t'(2), 1'b0);
		send_item(sample_t'(3), 1'b0);
		send_item(sample_t'(4), 1'b0);
		send_item(sample_t'(5), 1'b1);
		drain();

		kernel = '{tap_t'(-131072), '0, '0, '0, '0, '0, '0};
		write_kernel(0);
		send_item(sample_t'(-32768), 1'b0);
		send_item(sample_t'(32767), 1'b0);
		send_item(sample_t'(-1), 1'b1);
		drain();

		// small taps: truncation toward zero on negative sums
		kernel = '{tap_t'(16384), tap_t'(-16384), tap_t'(8192), tap_t'(-3),
			tap_t'(5000), '0, '0};
		write_kernel(2);
		send_item(sample_t'(-32768), 1'b0);
		send_item(sample_t'(-32768), 1'b0);
		send_item(sample_t'(7), 1'b0);
		send_item(sample_t'(-7), 1'b0);
		send_item(sample_t'(32767), 1'b0);
		send_item(sample_t'(1), 1'b1);
		drain();

		// fill the result buffer while the output holds off
		for (j = 0; j < NUM_TAPS; j++)
			kernel[j] = pick_tap();
		write_kernel(3);
		send_idle = 0;
		hold_req = 1'b1;
		send_line(40);
		drain();
		send_idle = 35;

		fed = 0;
		phase = 0;
		while (fed < RANDOM_ITEMS || phase < MIN_PHASES) begin
			for (j = 0; j < NUM_TAPS; j++)
				kernel[j] = pick_tap();
			write_kernel($urandom_range(3));
			if (phase == 2) begin
				send_idle = 0;
				recv_idle = 0;
			end else begin
				send_idle = 35;
				recv_idle = 35;
			end
			chunk = 0;
			while (chunk < 30) begin
				len = ($urandom_range(8) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
				send_line(len);
				chunk += len;
			end
			drain();
			fed += chunk;
			phase++;
		end

		if (tracker.mismatches == 0 && tracker.owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

`default_nettype wire
